// ===== hw/rtl/missing_sample_moving_average_fill_core_defines.svh =====
// Assertion macros shared by the gap-fill core RTL.
`ifndef MISSING_SAMPLE_MOVING_AVERAGE_FILL_CORE_DEFINES_SVH
`define MISSING_SAMPLE_MOVING_AVERAGE_FILL_CORE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define MSMAF_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define MSMAF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/msmaf_pkg.sv =====
// Shared constants and types for the gap-fill moving average core.
package msmaf_pkg;

    localparam int MAX_WINDOW  = 64;
    localparam int SAMPLE_BITS = 16;
    localparam int LEN_BITS    = 7;
    localparam int ADDR_BITS   = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int CNT_BITS    = $clog2(MAX_WINDOW + 1);
    localparam int SUM_BITS    = SAMPLE_BITS + $clog2(MAX_WINDOW) + 1;
    localparam int STEP_BITS   = $clog2(SUM_BITS);

    localparam logic signed [SAMPLE_BITS-1:0] MISSING_MARK = SAMPLE_BITS'(-16000);

    typedef logic signed [SAMPLE_BITS-1:0] sample_t;
    typedef logic signed [SUM_BITS-1:0]    sum_t;
    typedef logic [CNT_BITS-1:0]           cnt_t;
    typedef logic [ADDR_BITS-1:0]          addr_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DIV,
        S_PUSH
    } state_t;

endpackage

// ===== hw/rtl/msmaf_ram.sv =====
// Simple dual-port RAM, one write and one registered read per cycle.
module msmaf_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 16,
    parameter int ABITS = 6
) (
    input  logic             clk,
    input  logic             we,
    input  logic [ABITS-1:0] waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [ABITS-1:0] raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hw/rtl/msmaf_div.sv =====
// Bit-serial signed-by-unsigned divider, truncating toward zero.
module msmaf_div (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  msmaf_pkg::sum_t       dividend,
    input  msmaf_pkg::cnt_t       divisor,
    output logic                  done,
    output msmaf_pkg::sample_t    quotient
);

    logic                                busy_reg;
    logic                                done_reg;
    logic [msmaf_pkg::STEP_BITS-1:0]     step_reg;
    logic [msmaf_pkg::SUM_BITS-1:0]      quo_reg;
    logic [msmaf_pkg::CNT_BITS-1:0]      rem_reg;
    logic [msmaf_pkg::CNT_BITS-1:0]      den_reg;
    logic                                neg_reg;

    logic [msmaf_pkg::CNT_BITS:0]        trial;
    logic                                ge;
    logic [msmaf_pkg::SUM_BITS-1:0]      quo_signed;

    assign trial = {rem_reg, quo_reg[msmaf_pkg::SUM_BITS-1]};
    assign ge    = (trial >= {1'b0, den_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end
            else if (busy_reg)
            begin
                if (step_reg == msmaf_pkg::STEP_BITS'(msmaf_pkg::SUM_BITS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                step_reg <= step_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            neg_reg <= dividend[msmaf_pkg::SUM_BITS-1];
            quo_reg <= dividend[msmaf_pkg::SUM_BITS-1] ? (~dividend + 1'b1) : dividend;
            rem_reg <= '0;
            den_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? msmaf_pkg::CNT_BITS'(trial - {1'b0, den_reg})
                          : trial[msmaf_pkg::CNT_BITS-1:0];
            quo_reg <= {quo_reg[msmaf_pkg::SUM_BITS-2:0], ge};
        end
    end

    assign quo_signed = neg_reg ? (~quo_reg + 1'b1) : quo_reg;
    assign quotient   = quo_signed[msmaf_pkg::SAMPLE_BITS-1:0];
    assign done       = done_reg;

endmodule

// ===== hw/rtl/missing_sample_moving_average_fill_core.sv =====
// Gap-fill moving average core. Each item carries one signed sample in
// 1/16 degree; the value -16000 marks a missing sample. A present sample
// passes through the push state into the output register unchanged. A
// missing one is replaced by the truncated mean of the non-marker entries
// among the last window_length outputs, which are held in a 64-entry
// window RAM: the sequencer reads one entry per cycle, then a bit-serial
// divider runs 23 steps. One item is worked on at a time; a finished
// result sits in the output register while the next item is taken. No
// clearing pass is needed after reset.
`include "missing_sample_moving_average_fill_core_defines.svh"

module missing_sample_moving_average_fill_core (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [msmaf_pkg::LEN_BITS-1:0]    cfg_wdata,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic signed [msmaf_pkg::SAMPLE_BITS-1:0] sample,
    input  logic                              start_of_series,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic signed [msmaf_pkg::SAMPLE_BITS-1:0] filled_sample,
    output logic                              was_filled
);

    msmaf_pkg::state_t   state_reg, state_next;

    logic [msmaf_pkg::LEN_BITS-1:0] window_length_reg;
    msmaf_pkg::cnt_t     fill_reg;
    msmaf_pkg::addr_t    oldest_reg;
    msmaf_pkg::addr_t    rd_ptr_reg;
    msmaf_pkg::cnt_t     scan_left_reg;
    logic                rd_pending_reg;
    msmaf_pkg::sum_t     sum_reg;
    msmaf_pkg::cnt_t     cnt_reg;
    msmaf_pkg::sample_t  result_reg;
    logic                filled_reg;

    logic                out_valid_reg;
    msmaf_pkg::sample_t  out_sample_reg;
    logic                out_filled_reg;

    logic                accept;
    logic                out_free;
    logic                is_mark;
    msmaf_pkg::cnt_t     len_eff;
    msmaf_pkg::cnt_t     fill_eff;
    msmaf_pkg::addr_t    oldest_eff;
    msmaf_pkg::cnt_t     scan_n;
    msmaf_pkg::addr_t    first_ptr;
    logic                scan_end;

    logic                ram_re;
    logic                ram_we;
    logic                div_start;
    logic                load_out;
    msmaf_pkg::sample_t  ram_rdata;
    logic                div_done;
    msmaf_pkg::sample_t  div_quo;

    assign accept   = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;
    assign is_mark  = (sample == msmaf_pkg::MISSING_MARK);
    assign scan_end = (scan_left_reg == '0) && !rd_pending_reg;

    always_comb
    begin
        if (window_length_reg == '0)
        begin
            len_eff = msmaf_pkg::CNT_BITS'(1);
        end
        else if (int'(window_length_reg) > msmaf_pkg::MAX_WINDOW)
        begin
            len_eff = msmaf_pkg::CNT_BITS'(msmaf_pkg::MAX_WINDOW);
        end
        else
        begin
            len_eff = msmaf_pkg::CNT_BITS'(window_length_reg);
        end
    end

    assign fill_eff   = start_of_series ? '0 : fill_reg;
    assign oldest_eff = start_of_series ? '0 : oldest_reg;
    assign scan_n     = (fill_eff < len_eff) ? fill_eff : len_eff;
    assign first_ptr  = (oldest_eff == '0)
                        ? msmaf_pkg::ADDR_BITS'(msmaf_pkg::MAX_WINDOW - 1)
                        : oldest_eff - 1'b1;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            msmaf_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = is_mark ? msmaf_pkg::S_SCAN : msmaf_pkg::S_PUSH;
                end
            end
            msmaf_pkg::S_SCAN:
            begin
                if (scan_end)
                begin
                    state_next = (cnt_reg == '0) ? msmaf_pkg::S_PUSH : msmaf_pkg::S_DIV;
                end
            end
            msmaf_pkg::S_DIV:
            begin
                if (div_done)
                begin
                    state_next = msmaf_pkg::S_PUSH;
                end
            end
            msmaf_pkg::S_PUSH:
            begin
                if (out_free)
                begin
                    state_next = msmaf_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = msmaf_pkg::S_IDLE;
            end
        endcase
    end

    // outputs of the sequencer
    always_comb
    begin
        in_stall  = 1'b1;
        ram_re    = 1'b0;
        ram_we    = 1'b0;
        div_start = 1'b0;
        load_out  = 1'b0;
        case (state_reg)
            msmaf_pkg::S_IDLE:
            begin
                in_stall = 1'b0;
            end
            msmaf_pkg::S_SCAN:
            begin
                ram_re    = (scan_left_reg != '0);
                div_start = scan_end && (cnt_reg != '0);
            end
            msmaf_pkg::S_DIV:
            begin
            end
            msmaf_pkg::S_PUSH:
            begin
                ram_we   = out_free;
                load_out = out_free;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= msmaf_pkg::S_IDLE;
            window_length_reg <= msmaf_pkg::LEN_BITS'(2);
            fill_reg          <= '0;
            oldest_reg        <= '0;
            scan_left_reg     <= '0;
            rd_pending_reg    <= 1'b0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                window_length_reg <= cfg_wdata;
            end
            if (accept)
            begin
                fill_reg      <= fill_eff;
                oldest_reg    <= oldest_eff;
                scan_left_reg <= is_mark ? scan_n : '0;
            end
            else if (ram_re)
            begin
                scan_left_reg <= scan_left_reg - 1'b1;
            end
            rd_pending_reg <= ram_re;
            if (ram_we)
            begin
                oldest_reg <= (oldest_reg == msmaf_pkg::ADDR_BITS'(msmaf_pkg::MAX_WINDOW - 1))
                              ? '0 : oldest_reg + 1'b1;
                if (fill_reg != msmaf_pkg::CNT_BITS'(msmaf_pkg::MAX_WINDOW))
                begin
                    fill_reg <= fill_reg + 1'b1;
                end
            end
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rd_ptr_reg <= first_ptr;
            sum_reg    <= '0;
            cnt_reg    <= '0;
            result_reg <= is_mark ? '0 : sample;
            filled_reg <= is_mark;
        end
        else
        begin
            if (ram_re)
            begin
                rd_ptr_reg <= (rd_ptr_reg == '0)
                              ? msmaf_pkg::ADDR_BITS'(msmaf_pkg::MAX_WINDOW - 1)
                              : rd_ptr_reg - 1'b1;
            end
            if (rd_pending_reg && (ram_rdata != msmaf_pkg::MISSING_MARK))
            begin
                sum_reg <= sum_reg + msmaf_pkg::SUM_BITS'(ram_rdata);
                cnt_reg <= cnt_reg + 1'b1;
            end
            if (div_done)
            begin
                result_reg <= div_quo;
            end
        end
        if (load_out)
        begin
            out_sample_reg <= result_reg;
            out_filled_reg <= filled_reg;
        end
    end

    msmaf_ram #(
        .DEPTH (msmaf_pkg::MAX_WINDOW),
        .WIDTH (msmaf_pkg::SAMPLE_BITS),
        .ABITS (msmaf_pkg::ADDR_BITS)
    ) u_window (
        .clk   (clk),
        .we    (ram_we),
        .waddr (oldest_reg),
        .wdata (result_reg),
        .re    (ram_re),
        .raddr (rd_ptr_reg),
        .rdata (ram_rdata)
    );

    msmaf_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (sum_reg),
        .divisor  (cnt_reg),
        .done     (div_done),
        .quotient (div_quo)
    );

    assign out_valid     = out_valid_reg;
    assign filled_sample = out_sample_reg;
    assign was_filled    = out_filled_reg;

    `MSMAF_ASSERT_NEXT(a_accept_busy, accept, state_reg != msmaf_pkg::S_IDLE, "item taken but sequencer stayed idle")
    `MSMAF_ASSERT_NEXT(a_push_done, ram_we, state_reg == msmaf_pkg::S_IDLE, "window write did not end the item")
    `MSMAF_ASSERT_NOW(a_div_in_div, div_done, state_reg == msmaf_pkg::S_DIV, "divider finished outside divide state")
    `MSMAF_ASSERT_NOW(a_scan_bound, state_reg == msmaf_pkg::S_SCAN, (int'(cnt_reg) + int'(scan_left_reg)) <= int'(fill_reg), "scan counts exceed window fill")

endmodule
